### hw/rtl/cso_pkg.sv
// ----------------------------------------------------------------------------
// Characteristic sequence operator package
// Shared item types, operation codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package cso_pkg;

  localparam int unsigned SeqW = 128;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_QUESTION = 3'd1,
    OP_STAR     = 3'd2,
    OP_CONCAT   = 3'd3,
    OP_UNION    = 3'd4
  } op_e;

  localparam logic [7:0] RegPosLow  = 8'd0;
  localparam logic [7:0] RegPosHigh = 8'd1;
  localparam logic [7:0] RegNegLow  = 8'd2;
  localparam logic [7:0] RegNegHigh = 8'd3;
  localparam logic [7:0] RegCount   = 8'd4;
  localparam logic [7:0] RegFirst   = 8'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] left_low;
    logic [63:0] left_high;
    logic [63:0] right_low;
    logic [63:0] right_high;
    logic [6:0]  table_row;
    logic [2:0]  table_split;
    logic [6:0]  prefix_index;
    logic [6:0]  suffix_index;
    logic        entry_valid;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        fits_examples;
    logic        had_epsilon;
  } out_item_t;

  // One pipeline slot: operands, sequence built so far, and a pending load.
  typedef struct packed {
    logic            valid;
    op_e             op;
    logic [SeqW-1:0] l;
    logic [SeqW-1:0] r;
    logic [SeqW-1:0] cs;
    logic [6:0]      row;
    logic [2:0]      slot;
    logic [6:0]      pre;
    logic [6:0]      suf;
    logic            ev;
    logic            had_eps;
  } pipe_t;

  // Settings shared by every stage; the user keeps them stable while items are in flight (not enforced).
  typedef struct packed {
    logic [7:0] n;
    logic [7:0] first;
  } stage_cfg_t;

endpackage

`default_nettype wire

### hw/rtl/cso_stage.sv
// ----------------------------------------------------------------------------
// Characteristic sequence stage
// Owns one row of the split table and decides one sequence bit.
// ----------------------------------------------------------------------------
`default_nettype none

module cso_stage #(
  parameter int unsigned MaxSplits = 8,
  parameter int unsigned Ix        = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire cso_pkg::stage_cfg_t cfg_i,
  input  wire cso_pkg::pipe_t     pipe_i,
  output cso_pkg::pipe_t          pipe_o
);

  localparam logic [7:0] IxC = 8'(Ix);
  localparam logic [6:0] IxRow = 7'(Ix);
  localparam int unsigned SlotW = (MaxSplits > 1) ? $clog2(MaxSplits) : 1;

  logic [MaxSplits-1:0] ent_v_q;
  logic [6:0]           ent_p_q [MaxSplits];
  logic [6:0]           ent_s_q [MaxSplits];
  cso_pkg::pipe_t       pipe_q, pipe_d;
  logic                 wr;
  logic [SlotW-1:0]     wslot;
  logic [cso_pkg::SeqW-1:0] a, b;
  logic                 hit, live, active;

  assign wr = en_i && pipe_i.valid && (pipe_i.op == cso_pkg::OP_LOAD) &&
              (pipe_i.row == IxRow) && ({5'd0, pipe_i.slot} < 8'(MaxSplits));
  assign wslot = SlotW'(pipe_i.slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= '0;
    end else if (wr) begin
      ent_v_q[wslot] <= pipe_i.ev;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_p_q[wslot] <= pipe_i.pre;
      ent_s_q[wslot] <= pipe_i.suf;
    end
  end

  // The row scan stops at the first invalid entry.
  always_comb begin
    a = (pipe_i.op == cso_pkg::OP_STAR) ? pipe_i.cs : pipe_i.l;
    b = (pipe_i.op == cso_pkg::OP_STAR) ? pipe_i.cs : pipe_i.r;
    hit  = 1'b0;
    live = 1'b1;
    for (int k = 0; k < MaxSplits; k++) begin
      live = live && ent_v_q[k];
      hit  = hit || (live && a[ent_p_q[k]] && b[ent_s_q[k]]);
    end
    active = pipe_i.valid &&
             ((pipe_i.op == cso_pkg::OP_STAR) || (pipe_i.op == cso_pkg::OP_CONCAT)) &&
             (IxC >= cfg_i.first) && (IxC < cfg_i.n);
    pipe_d = pipe_i;
    if (active && hit) begin
      pipe_d.cs[Ix] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

`default_nettype wire

### hw/rtl/char_sequence_regex_ops.sv
// ----------------------------------------------------------------------------
// Characteristic sequence regex operators
// Question, star, concatenation and union over 128-bit infix sequences.
// ----------------------------------------------------------------------------
// A result passes through one entry register and one register per infix
// stage, with the output taken from the last stage. One item enters per
// cycle while the chain is not held; there is one stage per infix index.
// The whole chain advances together and holds while a result is not taken.
// Reset clears all valid bits, the split-entry valid bits and the pipeline
// registers, and sets the configuration registers to their defaults.
`default_nettype none

module char_sequence_regex_ops #(
  parameter int unsigned SEQUENCE_BITS = 128,
  parameter int unsigned MAX_SPLITS    = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire cso_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output cso_pkg::out_item_t       out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [7:0]          cfg_index_i,
  input  wire logic [63:0]         cfg_data_i
);

  localparam int unsigned W = cso_pkg::SeqW;

  logic [W-1:0] pos_q, neg_q;
  logic [7:0]   count_q, first_q;
  cso_pkg::stage_cfg_t scfg;
  logic [W-1:0] m;
  logic         en;
  cso_pkg::pipe_t entry_d, entry_q;
  cso_pkg::pipe_t chain [SEQUENCE_BITS+1];
  logic [W-1:0] l, r, res, pm, nm;
  cso_pkg::pipe_t last;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      neg_q   <= '0;
      count_q <= 8'd128;
      first_q <= 8'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cso_pkg::RegPosLow:  pos_q[63:0]   <= cfg_data_i;
        cso_pkg::RegPosHigh: pos_q[127:64] <= cfg_data_i;
        cso_pkg::RegNegLow:  neg_q[63:0]   <= cfg_data_i;
        cso_pkg::RegNegHigh: neg_q[127:64] <= cfg_data_i;
        cso_pkg::RegCount:   count_q       <= cfg_data_i[7:0];
        cso_pkg::RegFirst:   first_q       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The active count saturates at the sequence width; bits at or above it
  // are cleared everywhere.
  assign scfg.n     = (count_q > 8'(SEQUENCE_BITS)) ? 8'(SEQUENCE_BITS) : count_q;
  assign scfg.first = first_q;

  always_comb begin
    for (int i = 0; i < W; i++) begin
      m[i] = (8'(i) < scfg.n) && (i < 128);
    end
  end

  // The chain moves only when the result slot is free or being taken.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Entry stage: mask the operands and form the starting sequence.
  always_comb begin
    l = {in_item_i.left_high, in_item_i.left_low} & m;
    r = {in_item_i.right_high, in_item_i.right_low} & m;
    entry_d         = '0;
    entry_d.valid   = in_valid_i && (in_item_i.mode <= 3'(cso_pkg::OP_UNION));
    entry_d.op      = cso_pkg::op_e'(in_item_i.mode);
    entry_d.l       = l;
    entry_d.r       = r;
    entry_d.row     = in_item_i.table_row;
    entry_d.slot    = in_item_i.table_split;
    entry_d.pre     = in_item_i.prefix_index;
    entry_d.suf     = in_item_i.suffix_index;
    entry_d.ev      = in_item_i.entry_valid;
    case (in_item_i.mode)
      cso_pkg::OP_QUESTION: begin
        entry_d.cs      = l | W'(1);
        entry_d.had_eps = l[0];
      end
      cso_pkg::OP_STAR:   entry_d.cs = l | W'(1);
      cso_pkg::OP_CONCAT: entry_d.cs = (l[0] ? r : '0) | (r[0] ? l : '0);
      cso_pkg::OP_UNION:  entry_d.cs = l | r;
      default:            entry_d.cs = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en) begin
      entry_q <= entry_d;
    end
  end

  // One stage per infix index, in ascending order, so star sees the bits
  // set by lower indices. A load item writes its row as it passes.
  assign chain[0] = entry_q;

  for (genvar g = 0; g < SEQUENCE_BITS; g++) begin : g_stage
    cso_stage #(
      .MaxSplits(MAX_SPLITS),
      .Ix       (g)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .cfg_i (scfg),
      .pipe_i(chain[g]),
      .pipe_o(chain[g+1])
    );
  end

  assign last = chain[SEQUENCE_BITS];

  // Loads leave the chain without a result.
  assign out_valid_o = last.valid && (last.op != cso_pkg::OP_LOAD);

  always_comb begin
    res = last.cs & m;
    pm  = pos_q & m;
    nm  = neg_q & m;
    out_item_o.result_low    = res[63:0];
    out_item_o.result_high   = res[127:64];
    out_item_o.fits_examples = ((res & pm) == pm) && ((res & nm) == '0);
    out_item_o.had_epsilon   = last.had_eps;
  end

endmodule

`default_nettype wire

### hw/rtl/cso_checker.sv
// ----------------------------------------------------------------------------
// Characteristic sequence checker
// Port-level properties of the operator block.
// ----------------------------------------------------------------------------
`default_nettype none

module cso_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire cso_pkg::out_item_t out_item_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // The chain does not take items while its result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken during stall");

  // A question item whose left operand has epsilon keeps epsilon in the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.had_epsilon |-> out_item_o.result_low[0])
    else $error("epsilon lost");

  // No result in the cycle after reset is released.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind char_sequence_regex_ops cso_checker u_cso_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

`default_nettype wire
